// File: sv/rgbds_pkg.sv
package rgbds_pkg;

   // Register index of the configuration port.
   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SRC_WIDTH  = 2'd0,
      CSR_SRC_HEIGHT = 2'd1,
      CSR_DST_WIDTH  = 2'd2,
      CSR_DST_HEIGHT = 2'd3
   } csr_index_type;

   // Register values after reset.
   localparam int RESET_SRC_WIDTH  = 320;
   localparam int RESET_SRC_HEIGHT = 240;
   localparam int RESET_DST_WIDTH  = 192;
   localparam int RESET_DST_HEIGHT = 192;

   // Luma weights, summed and shifted right by eight.
   localparam logic [7:0] WEIGHT_RED   = 8'd77;
   localparam logic [7:0] WEIGHT_GREEN = 8'd150;
   localparam logic [7:0] WEIGHT_BLUE  = 8'd29;
   localparam logic [7:0] GRAY_OFFSET  = 8'd128;

endpackage

// File: sv/rgb565_gray_nearest_downscale.sv
// Channel   Direction  Handshake        Beat contents
// req_      in         valid / stall    pixel (RGB565)
// rsp_      out        valid / stall    gray, row_end, frame_end
// csr_      in         valid / ready    index, data (one size register)
//
// One pixel can be accepted every cycle while req_stall is low; a picked pixel
// passes the decimation stage register, then the luma stage into the output
// register, before it appears on rsp_. Unpicked pixels only advance the counters.
// After reset and after every register write, req_stall is high for one cycle
// while the saturated sizes and the row product are reloaded.
// rsp_stall holds the output register; the decimation stage still takes one
// more pixel behind it before req_stall rises.
module rgb565_gray_nearest_downscale #(
   parameter int COORD_BITS = 12
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [15:0]                               req_pixel,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [7:0]                         rsp_gray,
   output logic                                      rsp_row_end,
   output logic                                      rsp_frame_end,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [rgbds_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [COORD_BITS-1:0]                     csr_data
);
   import rgbds_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int NB = 2 * COORD_BITS;

   // Size registers.
   logic [CB-1:0] src_width_ff, src_height_ff, dst_width_ff, dst_height_ff;
   // Saturated sizes and the end-of-row product, reloaded after each write.
   logic [CB-1:0] sw_ff, sh_ff, dw_ff, dh_ff;
   logic [CB-1:0] sw_in, sh_in, dw_in, dh_in;
   logic [CB-1:0] dw_raw, dh_raw;
   logic [NB-1:0] limit_ff, limit_in;
   logic          pending_ff;

   // Scan state.
   logic [CB-1:0] src_col_ff, src_row_ff, orc_ff;
   logic [CB-1:0] src_col_in, src_row_in, orc_in;
   logic [NB-1:0] col_num_ff, col_base_ff, row_num_ff, row_base_ff;
   logic [NB-1:0] col_num_in, col_base_in, row_num_in, row_base_in;

   // Pipeline.
   logic          s1_valid_ff, s1_valid_in;
   logic [15:0]   s1_pixel_ff;
   logic          s1_row_end_ff, s1_frame_end_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic signed [7:0] rsp_gray_ff;
   logic          rsp_row_end_ff, rsp_frame_end_ff;
   logic signed [7:0] luma_gray;

   logic          accept, s1_move, csr_write;
   logic          row_pick, col_pick, pick, is_row_end, is_frame_end;
   logic          last_col, row_done;
   logic [NB:0]   col_num_plus;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= CB'(RESET_SRC_WIDTH);
         src_height_ff <= CB'(RESET_SRC_HEIGHT);
         dst_width_ff  <= CB'(RESET_DST_WIDTH);
         dst_height_ff <= CB'(RESET_DST_HEIGHT);
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_SRC_WIDTH:  src_width_ff  <= csr_data;
            CSR_SRC_HEIGHT: src_height_ff <= csr_data;
            CSR_DST_WIDTH:  dst_width_ff  <= csr_data;
            CSR_DST_HEIGHT: dst_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // A zero size acts as one; destination sizes saturate to the source.
   always_comb begin
      sw_in  = (src_width_ff == '0) ? CB'(1) : src_width_ff;
      sh_in  = (src_height_ff == '0) ? CB'(1) : src_height_ff;
      dw_raw = (dst_width_ff == '0) ? CB'(1) : dst_width_ff;
      dh_raw = (dst_height_ff == '0) ? CB'(1) : dst_height_ff;
      dw_in  = (dw_raw > sw_in) ? sw_in : dw_raw;
      dh_in  = (dh_raw > sh_in) ? sh_in : dh_raw;
      limit_in = NB'(dw_in) * NB'(sw_in);
   end

   always_ff @(posedge clock) begin
      sw_ff    <= sw_in;
      sh_ff    <= sh_in;
      dw_ff    <= dw_in;
      dh_ff    <= dh_in;
      limit_ff <= limit_in;
   end

   // Hold off pixels for one cycle while the derived sizes settle.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b1;
      end else begin
         pending_ff <= csr_write;
      end
   end

   // Handshake of the two stages.
   assign s1_move   = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = pending_ff | (s1_valid_ff & ~s1_move);
   assign accept    = req_valid & ~req_stall;

   // Pick decision from the running numerators and bases.
   always_comb begin
      row_pick = (orc_ff < dh_ff)
               && ({1'b0, row_num_ff} < ({1'b0, row_base_ff} + (NB+1)'(dh_ff)));
      col_pick = (col_num_ff < limit_ff)
               && ({1'b0, col_num_ff} < ({1'b0, col_base_ff} + (NB+1)'(dw_ff)));
      pick = row_pick & col_pick;
      col_num_plus = {1'b0, col_num_ff} + (NB+1)'(sw_ff);
      is_row_end   = col_num_plus >= {1'b0, limit_ff};
      is_frame_end = is_row_end && (({1'b0, orc_ff} + (CB+1)'(1)) >= {1'b0, dh_ff});
      last_col = ({1'b0, src_col_ff} + (CB+1)'(1)) >= {1'b0, sw_ff};
      row_done = ({1'b0, src_row_ff} + (CB+1)'(1)) >= {1'b0, sh_ff};
   end

   // Counter updates for one accepted pixel.
   always_comb begin
      src_col_in  = src_col_ff;
      src_row_in  = src_row_ff;
      orc_in      = orc_ff;
      col_num_in  = col_num_ff;
      col_base_in = col_base_ff;
      row_num_in  = row_num_ff;
      row_base_in = row_base_ff;
      if (accept) begin
         if (pick) begin
            col_num_in = col_num_plus[NB-1:0];
         end
         if (!last_col) begin
            src_col_in  = src_col_ff + CB'(1);
            col_base_in = col_base_ff + NB'(dw_ff);
         end else begin
            src_col_in  = '0;
            col_num_in  = '0;
            col_base_in = '0;
            if (row_done) begin
               src_row_in  = '0;
               orc_in      = '0;
               row_num_in  = '0;
               row_base_in = '0;
            end else begin
               if (row_pick) begin
                  row_num_in = row_num_ff + NB'(sh_ff);
                  orc_in     = orc_ff + CB'(1);
               end
               row_base_in = row_base_ff + NB'(dh_ff);
               src_row_in  = src_row_ff + CB'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff  <= '0;
         src_row_ff  <= '0;
         orc_ff      <= '0;
         col_num_ff  <= '0;
         col_base_ff <= '0;
         row_num_ff  <= '0;
         row_base_ff <= '0;
      end else begin
         src_col_ff  <= src_col_in;
         src_row_ff  <= src_row_in;
         orc_ff      <= orc_in;
         col_num_ff  <= col_num_in;
         col_base_ff <= col_base_in;
         row_num_ff  <= row_num_in;
         row_base_ff <= row_base_in;
      end
   end

   // Decimation stage: holds a picked pixel and its marks.
   assign s1_valid_in = accept ? pick : (s1_move ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff     <= req_pixel;
         s1_row_end_ff   <= is_row_end;
         s1_frame_end_ff <= is_frame_end;
      end
   end

   // Luma stage into the output register.
   rgbds_luma u_luma (
      .pixel (s1_pixel_ff),
      .gray  (luma_gray)
   );

   assign rsp_valid_in = s1_move ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_gray_ff      <= luma_gray;
         rsp_row_end_ff   <= s1_row_end_ff;
         rsp_frame_end_ff <= s1_frame_end_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_gray      = rsp_gray_ff;
   assign rsp_row_end   = rsp_row_end_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

   // The frame mark only comes with a row mark.
   a_frame_has_row_end : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_row_end)
      else $error("frame_end without row_end");

   // A register write blocks pixels in the following cycle.
   a_stall_after_write : assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> req_stall)
      else $error("pixel accepted while sizes reload");

   // A full pipeline behind a stalled output takes no new pixel.
   a_full_stalls : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && rsp_stall |-> req_stall)
      else $error("pixel accepted into a full pipeline");

   // The decimation stage only hands over into a free output register.
   a_move_into_free : assert property (@(posedge clock) disable iff (reset)
      s1_move |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwritten while stalled");

endmodule

// File: sv/rgbds_luma.sv
module rgbds_luma (
   input  logic [15:0]       pixel,
   output logic signed [7:0] gray
);
   import rgbds_pkg::*;

   // Stretch a 5-bit channel to 0..255, rounded down. v*255/31 is 8*v plus
   // the whole part of 7*v/31, which steps up at each listed threshold.
   function automatic logic [7:0] expand5(input logic [4:0] v);
      logic [7:0] r;
      r = {v, 3'b000};
      if (v >= 5'd5)  r = r + 8'd1;
      if (v >= 5'd9)  r = r + 8'd1;
      if (v >= 5'd14) r = r + 8'd1;
      if (v >= 5'd18) r = r + 8'd1;
      if (v >= 5'd23) r = r + 8'd1;
      if (v >= 5'd27) r = r + 8'd1;
      if (v >= 5'd31) r = r + 8'd1;
      return r;
   endfunction

   // Stretch a 6-bit channel to 0..255, rounded down. v*255/63 is 4*v plus
   // the whole part of v/21.
   function automatic logic [7:0] expand6(input logic [5:0] v);
      logic [7:0] r;
      r = {v, 2'b00};
      if (v >= 6'd21) r = r + 8'd1;
      if (v >= 6'd42) r = r + 8'd1;
      if (v >= 6'd63) r = r + 8'd1;
      return r;
   endfunction

   logic [7:0]  red8;
   logic [7:0]  green8;
   logic [7:0]  blue8;
   logic [15:0] weighted_sum;
   logic [7:0]  luma;

   // Expand each channel to 8 bits.
   assign red8   = expand5(pixel[15:11]);
   assign green8 = expand6(pixel[10:5]);
   assign blue8  = expand5(pixel[4:0]);

   // Weighted sum stays below 65536, so 16 bits suffice.
   assign weighted_sum = 16'(red8) * 16'(WEIGHT_RED) + 16'(green8) * 16'(WEIGHT_GREEN)
                       + 16'(blue8) * 16'(WEIGHT_BLUE);
   assign luma = weighted_sum[15:8];

   // Shift the range to signed -128..127.
   assign gray = signed'(luma - GRAY_OFFSET);

endmodule
